// File: hdl/i2c_master_byte_sequencer_core_macros.svh
// assertion macros shared by the i2c sequencer files
`ifndef I2C_MASTER_BYTE_SEQUENCER_CORE_MACROS_SVH
`define I2C_MASTER_BYTE_SEQUENCER_CORE_MACROS_SVH

// property that must hold in the same cycle, ignored while in reset
`define I2CMS_ASSERT_NOW(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// implication whose consequent is checked in the next cycle, ignored while in reset
`define I2CMS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: hdl/i2cms_pkg.sv
// shared types and codes for the i2c master byte sequencer
package i2cms_pkg;

    // command codes carried by an input request
    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_START   = 3'd1;
    localparam logic [2:0] CMD_RESTART = 3'd2;
    localparam logic [2:0] CMD_STOP    = 3'd3;
    localparam logic [2:0] CMD_WRITE   = 3'd4;
    localparam logic [2:0] CMD_READ    = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_BIT_DELAY     = 2'd0;
    localparam logic [1:0] REG_RESTART_EXTRA = 2'd1;
    localparam logic [1:0] REG_ACK_TIMEOUT   = 2'd2;

    // configuration reset values
    localparam logic [7:0] BIT_DELAY_RST     = 8'd4;
    localparam logic [3:0] RESTART_EXTRA_RST = 4'd2;
    localparam logic [7:0] ACK_TIMEOUT_RST   = 8'd250;

    // number of data bits in a byte transfer
    localparam logic [3:0] BYTE_BITS = 4'd8;

    typedef struct packed {
        logic [7:0] bit_delay_ticks;
        logic [3:0] restart_extra_ticks;
        logic [7:0] ack_timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] data_byte;
        logic       send_ack;
        logic       sda_in;
    } in_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_value;
        logic       ack_failed;
    } out_t;

endpackage

// File: hdl/i2cms_seq.sv
// bus phase sequencer: holds the phase state and works out one tick's result
`include "i2c_master_byte_sequencer_core_macros.svh"

module i2cms_seq (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  i2cms_pkg::in_t   req,
    input  i2cms_pkg::cfg_t  cfg,
    output i2cms_pkg::out_t  res
);

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_ST_SETUP, PH_ST_HOLD, PH_ST_LOW,
        PH_SP_LOW, PH_SP_HIGH,
        PH_WB_DATA, PH_WB_HIGH, PH_WB_LOW,
        PH_AK_REL, PH_AK_HIGH, PH_AK_WAIT, PH_AK_END,
        PH_RB_HIGH, PH_RB_LOW,
        PH_RK_DATA, PH_RK_HIGH, PH_RK_LOW, PH_RK_REL
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [8:0] tick_count_reg, tick_count_next;
    logic [3:0] bit_index_reg, bit_index_next;
    logic [7:0] shift_byte_reg, shift_byte_next;
    logic [7:0] ack_wait_count_reg, ack_wait_count_next;
    logic [2:0] active_command_reg, active_command_next;
    logic       ack_choice_reg, ack_choice_next;
    logic       scl_level_reg, scl_level_next;
    logic       sda_level_reg, sda_level_next;
    logic       ack_fail_flag_reg, ack_fail_flag_next;
    logic [7:0] read_result_reg, read_result_next;

    logic       out_scl;
    logic       out_sda;
    logic       busy;
    logic       done;
    logic       go;
    phase_t     target;
    logic [8:0] tick_inc;
    logic [8:0] phase_len;

    // next state and tick result
    always_comb begin
        phase_next          = phase_reg;
        tick_count_next     = tick_count_reg;
        bit_index_next      = bit_index_reg;
        shift_byte_next     = shift_byte_reg;
        ack_wait_count_next = ack_wait_count_reg;
        active_command_next = active_command_reg;
        ack_choice_next     = ack_choice_reg;
        scl_level_next      = scl_level_reg;
        sda_level_next      = sda_level_reg;
        ack_fail_flag_next  = ack_fail_flag_reg;
        read_result_next    = read_result_reg;
        done                = 1'b0;
        go                  = 1'b0;
        target              = phase_reg;
        tick_inc            = 9'd0;
        phase_len           = 9'd1;

        // command start, only from idle
        if (phase_reg == PH_IDLE) begin
            unique case (req.cmd) inside
                i2cms_pkg::CMD_START, i2cms_pkg::CMD_RESTART: begin
                    active_command_next = req.cmd;
                    bit_index_next      = 4'd0;
                    tick_count_next     = 9'd0;
                    phase_next          = PH_ST_SETUP;
                    sda_level_next      = 1'b1;
                    scl_level_next      = 1'b1;
                end
                i2cms_pkg::CMD_STOP: begin
                    active_command_next = req.cmd;
                    bit_index_next      = 4'd0;
                    tick_count_next     = 9'd0;
                    phase_next          = PH_SP_LOW;
                    sda_level_next      = 1'b0;
                    scl_level_next      = 1'b1;
                end
                i2cms_pkg::CMD_WRITE: begin
                    active_command_next = req.cmd;
                    bit_index_next      = 4'd0;
                    tick_count_next     = 9'd0;
                    ack_fail_flag_next  = 1'b0;
                    sda_level_next      = req.data_byte[7];
                    shift_byte_next     = {req.data_byte[6:0], 1'b0};
                    phase_next          = PH_WB_DATA;
                end
                i2cms_pkg::CMD_READ: begin
                    active_command_next = req.cmd;
                    bit_index_next      = 4'd0;
                    tick_count_next     = 9'd0;
                    ack_choice_next     = req.send_ack;
                    shift_byte_next     = 8'd0;
                    phase_next          = PH_RB_HIGH;
                    sda_level_next      = 1'b1;
                    scl_level_next      = 1'b1;
                end
                default: begin
                end
            endcase
        end

        // lines are shown as they stand once the command has begun
        out_scl = scl_level_next;
        out_sda = sda_level_next;
        busy    = (phase_next != PH_IDLE);

        // phase length, repeated start setup and hold are stretched
        phase_len = (cfg.bit_delay_ticks == 8'd0) ? 9'd1 : {1'b0, cfg.bit_delay_ticks};
        if (active_command_next == i2cms_pkg::CMD_RESTART &&
            (phase_next == PH_ST_SETUP || phase_next == PH_ST_HOLD)) begin
            phase_len = phase_len + {5'd0, cfg.restart_extra_ticks};
        end

        // phase timing and advance
        if (phase_next == PH_AK_WAIT) begin
            if (!req.sda_in) begin
                go     = 1'b1;
                target = PH_AK_END;
            end else if (ack_wait_count_next >= cfg.ack_timeout_ticks) begin
                ack_fail_flag_next = 1'b1;
                go                 = 1'b1;
                target             = PH_SP_LOW;
            end else begin
                ack_wait_count_next = ack_wait_count_next + 8'd1;
            end
        end else if (phase_next != PH_IDLE) begin
            tick_inc = tick_count_next + 9'd1;
            if (tick_inc >= phase_len) begin
                go = 1'b1;
                if (phase_next == PH_RB_HIGH) begin
                    shift_byte_next = {shift_byte_next[6:0], req.sda_in};
                    if (bit_index_next == 4'd7) begin
                        read_result_next = shift_byte_next;
                    end
                end
                unique case (phase_next)
                    PH_ST_SETUP: target = PH_ST_HOLD;
                    PH_ST_HOLD:  target = PH_ST_LOW;
                    PH_SP_LOW:   target = PH_SP_HIGH;
                    PH_WB_DATA:  target = PH_WB_HIGH;
                    PH_WB_HIGH:  target = PH_WB_LOW;
                    PH_WB_LOW: begin
                        bit_index_next = bit_index_next + 4'd1;
                        target = (bit_index_next < i2cms_pkg::BYTE_BITS) ? PH_WB_DATA
                                                                         : PH_AK_REL;
                    end
                    PH_AK_REL:   target = PH_AK_HIGH;
                    PH_AK_HIGH:  target = PH_AK_WAIT;
                    PH_RB_HIGH:  target = PH_RB_LOW;
                    PH_RB_LOW: begin
                        bit_index_next = bit_index_next + 4'd1;
                        target = (bit_index_next < i2cms_pkg::BYTE_BITS) ? PH_RB_HIGH
                                                                         : PH_RK_DATA;
                    end
                    PH_RK_DATA:  target = PH_RK_HIGH;
                    PH_RK_HIGH:  target = PH_RK_LOW;
                    PH_RK_LOW:   target = ack_choice_next ? PH_RK_REL : PH_IDLE;
                    default:     target = PH_IDLE;
                endcase
                done = (target == PH_IDLE);
            end else begin
                tick_count_next = tick_inc;
            end
        end

        // entry actions of the new phase
        if (go) begin
            phase_next      = target;
            tick_count_next = 9'd0;
            unique case (target)
                PH_ST_HOLD:  sda_level_next = 1'b0;
                PH_ST_LOW:   scl_level_next = 1'b0;
                PH_SP_LOW: begin
                    sda_level_next = 1'b0;
                    scl_level_next = 1'b1;
                end
                PH_SP_HIGH:  sda_level_next = 1'b1;
                PH_WB_DATA: begin
                    sda_level_next  = shift_byte_next[7];
                    shift_byte_next = {shift_byte_next[6:0], 1'b0};
                end
                PH_WB_HIGH:  scl_level_next = 1'b1;
                PH_WB_LOW:   scl_level_next = 1'b0;
                PH_AK_REL:   sda_level_next = 1'b1;
                PH_AK_HIGH:  scl_level_next = 1'b1;
                PH_AK_WAIT:  ack_wait_count_next = 8'd0;
                PH_AK_END:   scl_level_next = 1'b0;
                PH_RB_HIGH: begin
                    sda_level_next = 1'b1;
                    scl_level_next = 1'b1;
                end
                PH_RB_LOW:   scl_level_next = 1'b0;
                PH_RK_DATA:  sda_level_next = !ack_choice_next;
                PH_RK_HIGH:  scl_level_next = 1'b1;
                PH_RK_LOW:   scl_level_next = 1'b0;
                PH_RK_REL:   sda_level_next = 1'b1;
                default: begin
                end
            endcase
        end

        res.scl_out    = out_scl;
        res.sda_out    = out_sda;
        res.busy_res   = busy;
        res.done_res   = done;
        res.read_value = read_result_next;
        res.ack_failed = ack_fail_flag_next;
    end

    // phase state, moves on each accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_IDLE;
            tick_count_reg     <= 9'd0;
            bit_index_reg      <= 4'd0;
            shift_byte_reg     <= 8'd0;
            ack_wait_count_reg <= 8'd0;
            active_command_reg <= i2cms_pkg::CMD_NONE;
            ack_choice_reg     <= 1'b0;
            scl_level_reg      <= 1'b1;
            sda_level_reg      <= 1'b1;
            ack_fail_flag_reg  <= 1'b0;
            read_result_reg    <= 8'd0;
        end else if (step_en) begin
            phase_reg          <= phase_next;
            tick_count_reg     <= tick_count_next;
            bit_index_reg      <= bit_index_next;
            shift_byte_reg     <= shift_byte_next;
            ack_wait_count_reg <= ack_wait_count_next;
            active_command_reg <= active_command_next;
            ack_choice_reg     <= ack_choice_next;
            scl_level_reg      <= scl_level_next;
            sda_level_reg      <= sda_level_next;
            ack_fail_flag_reg  <= ack_fail_flag_next;
            read_result_reg    <= read_result_next;
        end
    end

    // state checks
    `I2CMS_ASSERT_NOW(a_idle_tick_zero, (phase_reg != PH_IDLE) || (tick_count_reg == 9'd0), "tick count not cleared in idle")
    `I2CMS_ASSERT_NOW(a_bit_index_range, bit_index_reg <= i2cms_pkg::BYTE_BITS, "bit index past byte end")
    `I2CMS_ASSERT_NOW(a_ack_wait_bound, (phase_reg != PH_AK_WAIT) || (ack_wait_count_reg <= cfg.ack_timeout_ticks), "ack wait count beyond timeout")

endmodule

// File: hdl/i2c_master_byte_sequencer_core.sv
// top level of the i2c master byte sequencer: config registers and result register
//
// Each input request is one prescaler tick carrying the sampled SDA level and,
// while no command is running, optionally a command (start, repeated start,
// stop, write byte, read byte). Every accepted tick yields exactly one result
// with the SCL/SDA drive levels, busy/done flags, the last read byte and the
// acknowledge failure flag.
// The result of a tick sits in the output register in the cycle after the tick
// is accepted. Throughput: one tick per cycle while the receiver keeps up, set by
// the single pass of phase logic between the phase state and the output register.
// Back-pressure: s_ready is high while the output register is empty or being
// taken, so a stalled receiver holds the result and stops further ticks; no
// tick is dropped and the bus timing simply pauses. Reset (aresetn low,
// synchronous): phase idle, both lines released, flags and read byte cleared,
// config back to delay 4, restart extra 2, timeout 250. Configuration is written
// via cfg_wr_en/cfg_index/cfg_wdata, by the user only while idle (not enforced).
`include "i2c_master_byte_sequencer_core_macros.svh"

module i2c_master_byte_sequencer_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  i2cms_pkg::in_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output i2cms_pkg::out_t  m_data,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [7:0]       cfg_wdata
);

    i2cms_pkg::cfg_t cfg_reg;
    i2cms_pkg::out_t res;
    i2cms_pkg::out_t m_data_reg;
    logic            m_valid_reg;
    logic            step_en;

    assign s_ready = !m_valid_reg || m_ready;
    assign step_en = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bit_delay_ticks     <= i2cms_pkg::BIT_DELAY_RST;
            cfg_reg.restart_extra_ticks <= i2cms_pkg::RESTART_EXTRA_RST;
            cfg_reg.ack_timeout_ticks   <= i2cms_pkg::ACK_TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                i2cms_pkg::REG_BIT_DELAY:     cfg_reg.bit_delay_ticks     <= cfg_wdata;
                i2cms_pkg::REG_RESTART_EXTRA: cfg_reg.restart_extra_ticks <= cfg_wdata[3:0];
                i2cms_pkg::REG_ACK_TIMEOUT:   cfg_reg.ack_timeout_ticks   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // phase sequencer
    i2cms_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .req     (s_data),
        .cfg     (cfg_reg),
        .res     (res)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step_en) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            m_data_reg <= res;
        end
    end

    // result checks
    `I2CMS_ASSERT_NEXT(a_tick_gives_result, step_en, m_valid_reg, "accepted tick gave no result")
    `I2CMS_ASSERT_NOW(a_done_in_busy, !m_valid_reg || !m_data_reg.done_res || m_data_reg.busy_res, "done flagged on idle tick")

endmodule

// File: dv/tb_i2c_master_byte_sequencer_core.sv
// testbench for the i2c master byte sequencer: tick stream driver, bus predictor, result checker
`timescale 1ns / 1ps

module tb_i2c_master_byte_sequencer_core;

    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 200;
    localparam int HOLD_AFTER  = 700;

    // command codes with no meaning, sent to check they are ignored
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    // bus sequencer phases as tracked by the predictor
    typedef enum logic [4:0] {
        BUS_IDLE, START_SETUP, START_HOLD, START_LOW, STOP_LOW, STOP_HIGH,
        WR_DATA, WR_HIGH, WR_LOW, ACK_REL, ACK_HIGH, ACK_WAIT, ACK_END,
        RD_HIGH, RD_LOW, RACK_DATA, RACK_HIGH, RACK_LOW, RACK_REL
    } bus_phase_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    i2cms_pkg::in_t    s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    i2cms_pkg::out_t   m_data;
    logic              cfg_wr_en = 1'b0;
    logic [1:0]        cfg_index = i2cms_pkg::REG_BIT_DELAY;
    logic [7:0]        cfg_wdata = '0;

    // predicted sequencer state
    i2cms_pkg::cfg_t   bus_cfg = '{i2cms_pkg::BIT_DELAY_RST, i2cms_pkg::RESTART_EXTRA_RST,
                                   i2cms_pkg::ACK_TIMEOUT_RST};
    bus_phase_t        ph = BUS_IDLE;
    logic [8:0]        tick_cnt = '0;
    logic [3:0]        bit_cnt = '0;
    logic [7:0]        shreg = '0;
    logic [7:0]        ackwait_cnt = '0;
    logic [2:0]        cur_cmd = i2cms_pkg::CMD_NONE;
    logic              ack_sel = 1'b0;
    logic              scl_q = 1'b1;
    logic              sda_q = 1'b1;
    logic              fail_q = 1'b0;
    logic [7:0]        rdbyte = '0;

    i2cms_pkg::in_t    pending_ticks[$];
    i2cms_pkg::out_t   bus_expect[$];
    int   ticks_queued = 0;
    int   ticks_taken = 0;
    int   results_seen = 0;
    int   mismatches = 0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;
    int   rx_cycle = 0;
    int   stall_cycles = 0;

    i2c_master_byte_sequencer_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    // line levels set on entry to each phase
    function automatic void enter_phase(bus_phase_t p);
        ph = p;
        tick_cnt = '0;
        case (p)
            START_SETUP: begin sda_q = 1'b1; scl_q = 1'b1; end
            START_HOLD:  sda_q = 1'b0;
            START_LOW:   scl_q = 1'b0;
            STOP_LOW:    begin sda_q = 1'b0; scl_q = 1'b1; end
            STOP_HIGH:   sda_q = 1'b1;
            WR_DATA: begin
                sda_q = shreg[7];
                shreg = {shreg[6:0], 1'b0};
            end
            WR_HIGH:     scl_q = 1'b1;
            WR_LOW:      scl_q = 1'b0;
            ACK_REL:     sda_q = 1'b1;
            ACK_HIGH:    scl_q = 1'b1;
            ACK_WAIT:    ackwait_cnt = '0;
            ACK_END:     scl_q = 1'b0;
            RD_HIGH:     begin sda_q = 1'b1; scl_q = 1'b1; end
            RD_LOW:      scl_q = 1'b0;
            RACK_DATA:   sda_q = ~ack_sel;
            RACK_HIGH:   scl_q = 1'b1;
            RACK_LOW:    scl_q = 1'b0;
            RACK_REL:    sda_q = 1'b1;
            default: ;
        endcase
    endfunction

    // ticks the current phase lasts; a zero delay still holds one tick
    function automatic logic [8:0] phase_length();
        logic [8:0] d;
        d = (bus_cfg.bit_delay_ticks == 8'd0) ? 9'd1 : {1'b0, bus_cfg.bit_delay_ticks};
        if (cur_cmd == i2cms_pkg::CMD_RESTART && (ph == START_SETUP || ph == START_HOLD))
            d = d + {5'd0, bus_cfg.restart_extra_ticks};
        return d;
    endfunction

    // step to the following phase, returns 1 when the command is over
    function automatic bit leave_phase();
        case (ph)
            START_SETUP: begin enter_phase(START_HOLD); return 1'b0; end
            START_HOLD:  begin enter_phase(START_LOW); return 1'b0; end
            STOP_LOW:    begin enter_phase(STOP_HIGH); return 1'b0; end
            WR_DATA:     begin enter_phase(WR_HIGH); return 1'b0; end
            WR_HIGH:     begin enter_phase(WR_LOW); return 1'b0; end
            WR_LOW: begin
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt < i2cms_pkg::BYTE_BITS) enter_phase(WR_DATA);
                else enter_phase(ACK_REL);
                return 1'b0;
            end
            ACK_REL:     begin enter_phase(ACK_HIGH); return 1'b0; end
            ACK_HIGH:    begin enter_phase(ACK_WAIT); return 1'b0; end
            RD_HIGH:     begin enter_phase(RD_LOW); return 1'b0; end
            RD_LOW: begin
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt < i2cms_pkg::BYTE_BITS) enter_phase(RD_HIGH);
                else enter_phase(RACK_DATA);
                return 1'b0;
            end
            RACK_DATA:   begin enter_phase(RACK_HIGH); return 1'b0; end
            RACK_HIGH:   begin enter_phase(RACK_LOW); return 1'b0; end
            RACK_LOW: begin
                if (ack_sel) begin
                    enter_phase(RACK_REL);
                    return 1'b0;
                end
            end
            default: ;
        endcase
        ph = BUS_IDLE;
        tick_cnt = '0;
        return 1'b1;
    endfunction

    // predict the result of one accepted tick
    task automatic step_bus(i2cms_pkg::in_t t);
        i2cms_pkg::out_t r;
        r = '0;
        if (ph == BUS_IDLE && t.cmd >= i2cms_pkg::CMD_START && t.cmd <= i2cms_pkg::CMD_READ) begin
            cur_cmd = t.cmd;
            bit_cnt = '0;
            case (t.cmd)
                i2cms_pkg::CMD_START, i2cms_pkg::CMD_RESTART: enter_phase(START_SETUP);
                i2cms_pkg::CMD_STOP: enter_phase(STOP_LOW);
                i2cms_pkg::CMD_WRITE: begin
                    fail_q = 1'b0;
                    shreg = t.data_byte;
                    enter_phase(WR_DATA);
                end
                default: begin
                    ack_sel = t.send_ack;
                    shreg = '0;
                    enter_phase(RD_HIGH);
                end
            endcase
        end
        r.scl_out = scl_q;
        r.sda_out = sda_q;
        if (ph != BUS_IDLE) begin
            r.busy_res = 1'b1;
            if (ph == ACK_WAIT) begin
                // acknowledge wait: low ends it, too many highs abort with a stop
                if (!t.sda_in) begin
                    enter_phase(ACK_END);
                end else if (ackwait_cnt >= bus_cfg.ack_timeout_ticks) begin
                    fail_q = 1'b1;
                    enter_phase(STOP_LOW);
                end else begin
                    ackwait_cnt = ackwait_cnt + 8'd1;
                end
            end else begin
                tick_cnt = tick_cnt + 9'd1;
                if (tick_cnt >= phase_length()) begin
                    if (ph == RD_HIGH) begin
                        shreg = {shreg[6:0], t.sda_in};
                        if (bit_cnt == i2cms_pkg::BYTE_BITS - 4'd1) rdbyte = shreg;
                    end
                    r.done_res = leave_phase();
                end
            end
        end
        r.read_value = rdbyte;
        r.ack_failed = fail_q;
        bus_expect.push_back(r);
    endtask

    task automatic offer(logic [2:0] c, logic [7:0] b, logic a, logic sda);
        i2cms_pkg::in_t tk;
        tk.cmd = c;
        tk.data_byte = b;
        tk.send_ack = a;
        tk.sda_in = sda;
        pending_ticks.push_back(tk);
        ticks_queued++;
    endtask

    // one command and the ticks it should take; highs < 0 means no acknowledge at all
    task automatic queue_command(logic [2:0] op, logic [7:0] byte_val, logic ack_bit,
                                 int highs, bit cut);
        int d;
        int n;
        int wait_at;
        logic sda;
        logic [2:0] c;
        d = (bus_cfg.bit_delay_ticks == 8'd0) ? 1 : int'(bus_cfg.bit_delay_ticks);
        wait_at = 26 * d;
        case (op)
            i2cms_pkg::CMD_START:   n = 3 * d;
            i2cms_pkg::CMD_RESTART: n = 3 * d + 2 * int'(bus_cfg.restart_extra_ticks);
            i2cms_pkg::CMD_STOP:    n = 2 * d;
            i2cms_pkg::CMD_WRITE: begin
                if (highs < 0) n = wait_at + int'(bus_cfg.ack_timeout_ticks) + 1 + 2 * d;
                else n = wait_at + highs + 1 + d;
            end
            default:     n = 19 * d + (ack_bit ? d : 0);
        endcase
        // broken sequence: the next command lands while still busy
        if (cut) n = int'($urandom_range(1, n));
        for (int i = 0; i < n; i++) begin
            sda = 1'($urandom_range(0, 1));
            if (op == i2cms_pkg::CMD_WRITE && i >= wait_at)
                sda = (highs < 0 || i < wait_at + highs);
            c = i2cms_pkg::CMD_NONE;
            if (i == 0) c = op;
            else if ($urandom_range(0, 15) == 0) c = 3'($urandom_range(0, 7));
            if (i == 0) offer(c, byte_val, ack_bit, sda);
            else offer(c, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), sda);
        end
    endtask

    // random command mix until roughly count ticks are queued
    task automatic queue_random(int count);
        int start_at;
        int r;
        int highs;
        int lim;
        logic [2:0] op;
        start_at = ticks_queued;
        while (ticks_queued - start_at < count) begin
            r = $urandom_range(0, 99);
            if (r < 35) op = i2cms_pkg::CMD_WRITE;
            else if (r < 60) op = i2cms_pkg::CMD_READ;
            else if (r < 75) op = i2cms_pkg::CMD_START;
            else if (r < 85) op = i2cms_pkg::CMD_RESTART;
            else op = i2cms_pkg::CMD_STOP;
            lim = (bus_cfg.ack_timeout_ticks < 8'd3) ? int'(bus_cfg.ack_timeout_ticks) : 3;
            r = $urandom_range(0, 9);
            if (r < 7) highs = $urandom_range(0, lim);
            else if (r < 8) highs = int'(bus_cfg.ack_timeout_ticks);
            else highs = -1;
            queue_command(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), highs,
                          $urandom_range(0, 19) == 0);
            // idle ticks, some with unused command codes
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    r = $urandom_range(0, 2);
                    op = (r == 0) ? i2cms_pkg::CMD_NONE
                                  : ((r == 1) ? CMD_SPARE_A : CMD_SPARE_B);
                    offer(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    task automatic wait_results();
        while (ticks_taken != ticks_queued || bus_expect.size() != 0) @(posedge aclk);
    endtask

    // bring the sequencer to idle, then write all three registers
    task automatic set_config(logic [7:0] bd, logic [3:0] ex, logic [7:0] to);
        wait_results();
        while (ph != BUS_IDLE) begin
            offer(i2cms_pkg::CMD_NONE, 8'h00, 1'b0, 1'b1);
            wait_results();
        end
        repeat (4) @(posedge aclk);
        bus_cfg.bit_delay_ticks = bd;
        bus_cfg.restart_extra_ticks = ex;
        bus_cfg.ack_timeout_ticks = to;
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= i2cms_pkg::REG_BIT_DELAY;
        cfg_wdata <= bd;
        @(posedge aclk);
        cfg_index <= i2cms_pkg::REG_RESTART_EXTRA;
        cfg_wdata <= {4'd0, ex};
        @(posedge aclk);
        cfg_index <= i2cms_pkg::REG_ACK_TIMEOUT;
        cfg_wdata <= to;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // request driver: bursts of random length with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            burst_left = $urandom_range(1, 64);
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                step_bus(s_data);
                ticks_taken++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_ticks.size() != 0) begin
                    s_data <= pending_ticks.pop_front();
                    s_valid <= 1'b1;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 64);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver: stall pattern plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            rx_cycle++;
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (rx_cycle[9:8])
                    2'd0: m_ready <= 1'b1;
                    2'd1: m_ready <= ($urandom_range(0, 3) != 0);
                    2'd2: m_ready <= ($urandom_range(0, 1) == 1);
                    default: m_ready <= (rx_cycle % 7 != 0);
                endcase
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        i2cms_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (bus_expect.size() == 0) begin
                report_mismatch("result with nothing expected", int'(m_data), 0);
            end else begin
                want = bus_expect.pop_front();
                if (m_data.scl_out !== want.scl_out)
                    report_mismatch("scl_out", int'(m_data.scl_out), int'(want.scl_out));
                if (m_data.sda_out !== want.sda_out)
                    report_mismatch("sda_out", int'(m_data.sda_out), int'(want.sda_out));
                if (m_data.busy_res !== want.busy_res)
                    report_mismatch("busy_res", int'(m_data.busy_res), int'(want.busy_res));
                if (m_data.done_res !== want.done_res)
                    report_mismatch("done_res", int'(m_data.done_res), int'(want.done_res));
                if (m_data.read_value !== want.read_value)
                    report_mismatch("read_value", int'(m_data.read_value),
                                    int'(want.read_value));
                if (m_data.ack_failed !== want.ack_failed)
                    report_mismatch("ack_failed", int'(m_data.ack_failed),
                                    int'(want.ack_failed));
            end
        end
    end

    // watchdog on cycles with no request taken on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // stimulus
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // zero delay and zero timeout: every command at least once, unused codes
        set_config(8'd0, 4'd0, 8'd0);
        offer(CMD_SPARE_A, 8'h00, 1'b0, 1'b1);
        offer(CMD_SPARE_B, 8'hFF, 1'b1, 1'b0);
        offer(i2cms_pkg::CMD_NONE, 8'h00, 1'b0, 1'b1);
        queue_command(i2cms_pkg::CMD_START, 8'h00, 1'b0, 0, 1'b0);
        queue_command(i2cms_pkg::CMD_WRITE, 8'h00, 1'b0, 0, 1'b0);
        queue_command(i2cms_pkg::CMD_WRITE, 8'hFF, 1'b1, -1, 1'b0);
        queue_command(i2cms_pkg::CMD_WRITE, 8'h5A, 1'b0, 0, 1'b0);
        queue_command(i2cms_pkg::CMD_RESTART, 8'hFF, 1'b1, 0, 1'b0);
        queue_command(i2cms_pkg::CMD_READ, 8'h00, 1'b1, 0, 1'b0);
        queue_command(i2cms_pkg::CMD_READ, 8'hFF, 1'b0, 0, 1'b0);
        queue_command(i2cms_pkg::CMD_STOP, 8'hA5, 1'b1, 0, 1'b0);

        // shortest delay, longest restart extension, with a sender pause midway
        set_config(8'd1, 4'd15, 8'd3);
        queue_random(250);
        wait_results();
        queue_random(150);

        // the long receiver hold-off falls in this stretch
        set_config(8'd2, 4'd7, 8'd20);
        queue_random(350);

        // longest delay with the longest restart extension
        set_config(8'd255, 4'd15, 8'd255);
        queue_command(i2cms_pkg::CMD_RESTART, 8'h00, 1'b0, 0, 1'b0);

        // longest acknowledge timeout at the shortest delay
        set_config(8'd1, 4'd0, 8'd255);
        queue_command(i2cms_pkg::CMD_WRITE, 8'hC3, 1'b0, -1, 1'b0);

        // back to the power-up values
        set_config(i2cms_pkg::BIT_DELAY_RST, i2cms_pkg::RESTART_EXTRA_RST,
                   i2cms_pkg::ACK_TIMEOUT_RST);
        queue_random(100);

        wait_results();
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
